FILE: src/lgas_pkg.sv
// Shared types, action codes and constants for the aging Life grid.
// Used by every module of the block except lgas_ram; depends on nothing.
package lgas_pkg;

    localparam int GRID_WIDTH_DEF  = 8;
    localparam int GRID_HEIGHT_DEF = 8;
    localparam int AGE_W           = 3;
    localparam int GEN_W           = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 8;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_STEP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_LIMIT = 1'b1;

    localparam logic [AGE_W-1:0] MAX_AGE_RST   = 3'd7;
    localparam logic [GEN_W-1:0] GEN_LIMIT_RST = 8'd120;
    localparam logic [GEN_W-1:0] GEN_MAX       = 8'd255;

    typedef struct packed {
        logic [1:0]       action;
        logic [2:0]       col;
        logic [2:0]       row;
        logic [AGE_W-1:0] cell_age;
    } t_item;

    typedef struct packed {
        logic [AGE_W-1:0] read_age;
        logic             grid_empty;
        logic             grid_unchanged;
        logic             limit_reached;
        logic [GEN_W-1:0] generation;
    } t_result;

    // Classified command as it sits in the queue
    typedef struct packed {
        logic [1:0]       action;
        logic             on_grid;
        logic [2:0]       col;
        logic [2:0]       row;
        logic [AGE_W-1:0] cell_age;
    } t_cmd;

endpackage

FILE: src/life_grid_aging_step.sv
// Toroidal Life grid with cell ages. A clear is done from idle, a write or
// read passes through the cell state, and a step sweeps one row per cycle
// through the single read port of the row RAM. Results cannot be stalled.
// Reset: grid dead at once (row valid bits, no clearing pass), count 0,
// max_age 7, generation_limit 120.
module life_grid_aging_step #(
    parameter int GRID_WIDTH  = lgas_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = lgas_pkg::GRID_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  lgas_pkg::t_item                   i_item,
    output logic                              o_done,
    output lgas_pkg::t_result                 o_result,
    input  logic                              i_cfg_we,
    input  logic [lgas_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lgas_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [lgas_pkg::AGE_W-1:0] r_max_age;
    logic [lgas_pkg::GEN_W-1:0] r_gen_limit;

    logic           q_full;
    logic           q_empty;
    logic           push;
    logic           pop;
    lgas_pkg::t_cmd cmd;
    lgas_pkg::t_cmd head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age   <= lgas_pkg::MAX_AGE_RST;
            r_gen_limit <= lgas_pkg::GEN_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lgas_pkg::CFG_MAX_AGE:   r_max_age   <= i_cfg_data[lgas_pkg::AGE_W-1:0];
                lgas_pkg::CFG_GEN_LIMIT: r_gen_limit <= i_cfg_data[lgas_pkg::GEN_W-1:0];
                default: ;
            endcase
        end
    end

    lgas_front #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_front (
        .i_start (start),
        .i_full  (q_full),
        .i_item  (i_item),
        .o_busy  (busy),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    lgas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    lgas_back #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_age   (r_max_age),
        .i_gen_limit (r_gen_limit),
        .i_empty     (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule

FILE: src/lgas_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module lgas_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/lgas_front.sv
// Front end: takes a command beat, checks the cell address against the grid.
// Depends on lgas_pkg; feeds lgas_queue.
module lgas_front #(
    parameter int GRID_WIDTH  = lgas_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = lgas_pkg::GRID_HEIGHT_DEF
) (
    input  logic            i_start,
    input  logic            i_full,
    input  lgas_pkg::t_item i_item,
    output logic            o_busy,
    output logic            o_push,
    output lgas_pkg::t_cmd  o_cmd
);

    logic on_grid;

    assign on_grid = (int'(i_item.col) < GRID_WIDTH) && (int'(i_item.row) < GRID_HEIGHT);

    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    always_comb begin
        o_cmd          = '0;
        o_cmd.action   = i_item.action;
        o_cmd.on_grid  = on_grid;
        o_cmd.col      = i_item.col;
        o_cmd.row      = i_item.row;
        o_cmd.cell_age = i_item.cell_age;
    end

endmodule

FILE: src/lgas_queue.sv
// Short command queue between front and back end.
// Depends on lgas_pkg for the command type and depth.
module lgas_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lgas_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output lgas_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);

    localparam int QD  = lgas_pkg::QUEUE_DEPTH;
    localparam int PW  = (QD > 1) ? $clog2(QD) : 1;
    localparam int CNW = $clog2(QD + 1);

    lgas_pkg::t_cmd r_slot [QD];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CNW-1:0] r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNW'(QD));
    assign o_head  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_slot[r_wp] <= i_cmd;
                r_wp         <= (r_wp == PW'(QD - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(QD - 1)) ? '0 : r_rp + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNW'(1);
                2'b01:   r_cnt <= r_cnt - CNW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: src/lgas_back.sv
// Back end: executes clear, cell write/read and the generation step.
// Grid rows live in lgas_ram; depends on lgas_pkg.
module lgas_back #(
    parameter int GRID_WIDTH  = lgas_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = lgas_pkg::GRID_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lgas_pkg::AGE_W-1:0]  i_max_age,
    input  logic [lgas_pkg::GEN_W-1:0]  i_gen_limit,
    input  logic                        i_empty,
    input  lgas_pkg::t_cmd              i_head,
    output logic                        o_pop,
    output logic                        o_done,
    output lgas_pkg::t_result           o_result
);

    localparam int AW    = lgas_pkg::AGE_W;
    localparam int ROW_W = GRID_WIDTH * AW;
    localparam int RW    = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int CW    = $clog2(GRID_WIDTH);
    localparam int KW    = $clog2(GRID_HEIGHT + 2);
    localparam int RXW   = (RW > 3) ? RW : 3;
    localparam int CXW   = (CW > 3) ? CW : 3;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CELL = 2'd1;
    localparam logic [1:0] S_STEP = 2'd2;

    logic [1:0]             r_state;
    logic [KW-1:0]          r_k;
    lgas_pkg::t_cmd         r_cmd;
    logic [GRID_HEIGHT-1:0] r_valid;
    logic                   r_rd_valid;
    logic [ROW_W-1:0]       r_prev2;
    logic [ROW_W-1:0]       r_prev1;
    logic [ROW_W-1:0]       r_row0;
    logic                   r_any;
    logic                   r_same;
    logic [lgas_pkg::GEN_W-1:0] r_gen;
    logic                   r_done;
    lgas_pkg::t_result      r_res;

    logic                   ram_we;
    logic [RW-1:0]          ram_waddr;
    logic [ROW_W-1:0]       ram_wdata;
    logic [RW-1:0]          ram_raddr;
    logic [ROW_W-1:0]       ram_rdata;
    logic [ROW_W-1:0]       rd_eff;

    logic [RXW-1:0]         head_row_x;
    logic [RXW-1:0]         cmd_row_x;
    logic [CXW-1:0]         cmd_col_x;
    logic [CW-1:0]          col_i;
    logic [AW-1:0]          cell_rd;
    logic [ROW_W-1:0]       cell_row;

    logic [ROW_W-1:0]       up_row;
    logic [ROW_W-1:0]       mid_row;
    logic [ROW_W-1:0]       dn_row;
    logic [ROW_W-1:0]       new_row;
    logic [GRID_WIDTH-1:0]  up_l;
    logic [GRID_WIDTH-1:0]  mid_l;
    logic [GRID_WIDTH-1:0]  dn_l;
    logic [GRID_WIDTH-1:0]  new_l;
    logic                   row_any;
    logic                   row_same;
    logic [KW-1:0]          k_m2;
    logic                   step_wr;
    logic                   step_last;
    logic [lgas_pkg::GEN_W-1:0] gen_inc;

    lgas_ram #(
        .WIDTH (ROW_W),
        .DEPTH (GRID_HEIGHT)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // rows never written since clear read as dead
    assign rd_eff = r_rd_valid ? ram_rdata : '0;

    assign head_row_x = RXW'(i_head.row);
    assign cmd_row_x  = RXW'(r_cmd.row);
    assign cmd_col_x  = CXW'(r_cmd.col);
    assign col_i      = cmd_col_x[CW-1:0];

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    assign k_m2      = r_k - KW'(2);
    assign step_wr   = (r_state == S_STEP) && (r_k >= KW'(2));
    assign step_last = (r_k == KW'(GRID_HEIGHT + 1));
    assign gen_inc   = (r_gen != lgas_pkg::GEN_MAX) ? r_gen + 8'd1 : r_gen;

    // read address: the head's row for a cell access; for a step row H-1 first, then rows 0..H-1 in the sweep
    always_comb begin
        ram_raddr = '0;
        if (r_state == S_IDLE) begin
            if (i_head.action == lgas_pkg::ACT_STEP) begin
                ram_raddr = RW'(GRID_HEIGHT - 1);
            end else if (i_head.on_grid) begin
                ram_raddr = head_row_x[RW-1:0];
            end
        end else if (r_state == S_STEP && r_k < KW'(GRID_HEIGHT)) begin
            ram_raddr = r_k[RW-1:0];
        end
    end

    // single-cell access on the fetched row
    always_comb begin
        cell_rd  = '0;
        cell_row = rd_eff;
        for (int c = 0; c < GRID_WIDTH; c++) begin
            if (CW'(c) == col_i) begin
                cell_rd            = rd_eff[c*AW +: AW];
                cell_row[c*AW +: AW] = r_cmd.cell_age;
            end
        end
    end

    // one row of the generation: window of old rows above, at and below
    assign up_row  = r_prev2;
    assign mid_row = r_prev1;
    assign dn_row  = step_last ? r_row0 : rd_eff;

    always_comb begin
        for (int c = 0; c < GRID_WIDTH; c++) begin
            up_l[c]  = |up_row[c*AW +: AW];
            mid_l[c] = |mid_row[c*AW +: AW];
            dn_l[c]  = |dn_row[c*AW +: AW];
        end
    end

    always_comb begin
        logic [3:0]    n;
        logic [AW-1:0] a;
        logic [AW-1:0] nx;
        int            lc;
        int            rc;
        new_row = '0;
        new_l   = '0;
        for (int c = 0; c < GRID_WIDTH; c++) begin
            lc = (c == 0) ? GRID_WIDTH - 1 : c - 1;
            rc = (c == GRID_WIDTH - 1) ? 0 : c + 1;
            n  = 4'(up_l[lc]) + 4'(up_l[c]) + 4'(up_l[rc])
               + 4'(mid_l[lc]) + 4'(mid_l[rc])
               + 4'(dn_l[lc]) + 4'(dn_l[c]) + 4'(dn_l[rc]);
            a  = mid_row[c*AW +: AW];
            nx = '0;
            if (a != '0) begin
                if (n == 4'd2 || n == 4'd3) begin
                    nx = (a < i_max_age) ? a + 3'd1 : a;
                end
            end else if (n == 4'd3) begin
                nx = 3'd1;
            end
            new_row[c*AW +: AW] = nx;
            new_l[c]            = |nx;
        end
    end

    assign row_any  = |new_l;
    assign row_same = (new_row == mid_row);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = new_row;
        if (r_state == S_CELL && r_cmd.action == lgas_pkg::ACT_WRITE) begin
            ram_we    = 1'b1;
            ram_waddr = cmd_row_x[RW-1:0];
            ram_wdata = cell_row;
        end else if (step_wr) begin
            ram_we    = 1'b1;
            ram_waddr = k_m2[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_gen   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done     <= 1'b0;
            r_rd_valid <= r_valid[ram_raddr];
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        unique case (i_head.action) inside
                            lgas_pkg::ACT_CLEAR: begin
                                r_valid <= '0;
                                r_gen   <= '0;
                                r_done  <= 1'b1;
                                r_res   <= '0;
                            end
                            lgas_pkg::ACT_WRITE, lgas_pkg::ACT_READ: begin
                                if (i_head.on_grid) begin
                                    r_cmd   <= i_head;
                                    r_state <= S_CELL;
                                end else begin
                                    r_done           <= 1'b1;
                                    r_res            <= '0;
                                    r_res.generation <= r_gen;
                                end
                            end
                            default: begin
                                r_k     <= '0;
                                r_any   <= 1'b0;
                                r_same  <= 1'b1;
                                r_state <= S_STEP;
                            end
                        endcase
                    end
                end
                S_CELL: begin
                    r_done           <= 1'b1;
                    r_res            <= '0;
                    r_res.generation <= r_gen;
                    if (r_cmd.action == lgas_pkg::ACT_READ) begin
                        r_res.read_age <= cell_rd;
                    end
                    r_state <= S_IDLE;
                end
                S_STEP: begin
                    r_prev2 <= r_prev1;
                    r_prev1 <= rd_eff;
                    r_k     <= r_k + KW'(1);
                    if (r_k == KW'(1)) begin
                        r_row0 <= rd_eff;
                    end
                    if (step_wr) begin
                        r_any  <= r_any | row_any;
                        r_same <= r_same & row_same;
                    end
                    if (step_last) begin
                        r_gen                <= gen_inc;
                        r_done               <= 1'b1;
                        r_res.read_age       <= '0;
                        r_res.grid_empty     <= !(r_any | row_any);
                        r_res.grid_unchanged <= r_same & row_same;
                        r_res.limit_reached  <= (gen_inc >= i_gen_limit);
                        r_res.generation     <= gen_inc;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

FILE: sim/tb_life_grid_aging_step.sv
// Self-checking bench for life_grid_aging_step: drives clear/write/read/step
// commands and checks every result against a cycle-free model of the aged grid.
// Depends on lgas_pkg and the block itself.
module tb_life_grid_aging_step;
    import lgas_pkg::*;

    localparam int W            = GRID_WIDTH_DEF;
    localparam int H            = GRID_HEIGHT_DEF;
    localparam int CELLS        = W * H;
    localparam int ITEM_W       = $bits(t_item);
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    // Tracks the grid, count and registers; holds the results still owed
    class life_tracker;
        logic [AGE_W-1:0] ages [CELLS];
        logic [GEN_W-1:0] gen_count;
        logic [AGE_W-1:0] age_cap;
        logic [GEN_W-1:0] gen_limit;
        logic [GEN_W-1:0] top_gen;
        t_result          owed_results [$];
        int mismatches, n_clear, n_write, n_read, n_step, n_empty, n_same, n_limit;

        function new();
            foreach (ages[i]) ages[i] = '0;
            gen_count  = '0;
            age_cap    = MAX_AGE_RST;
            gen_limit  = GEN_LIMIT_RST;
            top_gen    = '0;
            mismatches = 0;
            n_clear    = 0;
            n_write    = 0;
            n_read     = 0;
            n_step     = 0;
            n_empty    = 0;
            n_same     = 0;
            n_limit    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_MAX_AGE) begin
                age_cap = data[AGE_W-1:0];
            end else if (idx == CFG_GEN_LIMIT) begin
                gen_limit = data[GEN_W-1:0];
            end
        endfunction

        function int live(int c, int r);
            return (ages[r * W + c] != '0) ? 1 : 0;
        endfunction

        // One generation on the torus; survivors at or above the cap keep their age
        function void advance(output logic empty, output logic same);
            logic [AGE_W-1:0] nxt [CELLS];
            int n, cl, cr, ru, rd, idx;
            empty = 1'b1;
            same  = 1'b1;
            for (int r = 0; r < H; r++) begin
                for (int c = 0; c < W; c++) begin
                    cl  = (c + W - 1) % W;
                    cr  = (c + 1) % W;
                    ru  = (r + H - 1) % H;
                    rd  = (r + 1) % H;
                    n   = live(cl, ru) + live(c, ru) + live(cr, ru) + live(cl, r)
                        + live(cr, r) + live(cl, rd) + live(c, rd) + live(cr, rd);
                    idx = r * W + c;
                    nxt[idx] = '0;
                    if (ages[idx] != '0) begin
                        if (n == 2 || n == 3)
                            nxt[idx] = (ages[idx] < age_cap) ? ages[idx] + 3'd1 : ages[idx];
                    end else if (n == 3) begin
                        nxt[idx] = 3'd1;
                    end
                    if (nxt[idx] != '0) empty = 1'b0;
                    if (nxt[idx] != ages[idx]) same = 1'b0;
                end
            end
            foreach (ages[i]) ages[i] = nxt[i];
        endfunction

        function void apply_cmd(t_item it);
            t_result res;
            logic    empty, same;
            logic    on_grid;
            res     = '0;
            on_grid = int'(it.col) < W && int'(it.row) < H;
            case (it.action)
                ACT_CLEAR: begin
                    foreach (ages[i]) ages[i] = '0;
                    gen_count = '0;
                    n_clear++;
                end
                ACT_WRITE: begin
                    if (on_grid) ages[int'(it.row) * W + int'(it.col)] = it.cell_age;
                    n_write++;
                end
                ACT_READ: begin
                    if (on_grid) res.read_age = ages[int'(it.row) * W + int'(it.col)];
                    n_read++;
                end
                ACT_STEP: begin
                    advance(empty, same);
                    if (gen_count != GEN_MAX) gen_count = gen_count + 8'd1;
                    res.grid_empty     = empty;
                    res.grid_unchanged = same;
                    res.limit_reached  = gen_count >= gen_limit;
                    n_step++;
                    if (empty) n_empty++;
                    if (same) n_same++;
                    if (res.limit_reached) n_limit++;
                end
            endcase
            res.generation = gen_count;
            if (gen_count > top_gen) top_gen = gen_count;
            owed_results.push_back(res);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 30) $display("mismatch: %s", msg);
        endtask

        task check_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                report("result beat with no command outstanding");
                return;
            end
            want = owed_results.pop_front();
            if (got.read_age !== want.read_age)
                report($sformatf("read_age %0d, want %0d", got.read_age, want.read_age));
            if (got.grid_empty !== want.grid_empty)
                report($sformatf("grid_empty %b, want %b", got.grid_empty, want.grid_empty));
            if (got.grid_unchanged !== want.grid_unchanged)
                report($sformatf("grid_unchanged %b, want %b",
                                 got.grid_unchanged, want.grid_unchanged));
            if (got.limit_reached !== want.limit_reached)
                report($sformatf("limit_reached %b, want %b (gen %0d)",
                                 got.limit_reached, want.limit_reached, want.generation));
            if (got.generation !== want.generation)
                report($sformatf("generation %0d, want %0d", got.generation, want.generation));
        endtask

        function int outstanding();
            return owed_results.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_item                 i_item;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    life_tracker tracker;
    bit          sender_idles;
    int          quiet_cycles = 0;

    life_grid_aging_step dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Results cannot be held off: every strobe is a beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) tracker.check_result(o_result);
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic t_item make_item(logic [1:0] act, int c, int r, int a);
        t_item it;
        it.action   = act;
        it.col      = 3'(c);
        it.row      = 3'(r);
        it.cell_age = AGE_W'(a);
        return it;
    endfunction

    // start is only ever lowered in a gap, so back-to-back beats keep it high
    task automatic send_beat(t_item it);
        if (sender_idles) begin
            while ($urandom_range(99) < 15) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tracker.apply_cmd(it);
    endtask

    task automatic set_config(logic [AGE_W-1:0] cap, logic [GEN_W-1:0] limit);
        logic [CFG_DATA_W-1:0] data;
        data       = {(CFG_DATA_W-AGE_W)'($urandom), cap};
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MAX_AGE;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.set_reg(CFG_MAX_AGE, data);
        i_cfg_idx  <= CFG_GEN_LIMIT;
        i_cfg_data <= limit;
        @(posedge i_clk);
        tracker.set_reg(CFG_GEN_LIMIT, limit);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Bursts: seed a small patch, run some generations, probe cells, plus noise
    task automatic run_phase(int n_items, int clear_pct, int step_pct);
        int         sent, pick, k;
        logic [2:0] c0, r0;
        t_item      it;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < clear_pct) begin
                send_beat(make_item(ACT_CLEAR, $urandom, $urandom, $urandom));
                sent++;
            end else if (pick < clear_pct + 5) begin
                it = t_item'(ITEM_W'($urandom));
                if (clear_pct == 0 && it.action == ACT_CLEAR) it.action = ACT_STEP;
                send_beat(it);
                sent++;
            end else if (pick < clear_pct + 5 + step_pct) begin
                k = $urandom_range(1, 8);
                repeat (k) begin
                    send_beat(make_item(ACT_STEP, $urandom, $urandom, $urandom));
                    sent++;
                end
            end else if (pick < 80) begin
                c0 = 3'($urandom);
                r0 = 3'($urandom);
                k  = $urandom_range(3, 10);
                repeat (k) begin
                    send_beat(make_item(ACT_WRITE,
                                        c0 + 3'($urandom_range(0, 3)) - 3'd1,
                                        r0 + 3'($urandom_range(0, 3)) - 3'd1,
                                        ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 7)));
                    sent++;
                end
            end else begin
                k = $urandom_range(1, 4);
                repeat (k) begin
                    send_beat(make_item(ACT_READ, $urandom, $urandom, $urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        tracker      = new();
        sender_idles = 1'b1;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: block wrapped over the corners with ages above, at and below the cap
        set_config(3'd3, 8'd2);
        send_beat(make_item(ACT_CLEAR, 0, 0, 0));
        send_beat(make_item(ACT_WRITE, 7, 7, 7));
        send_beat(make_item(ACT_WRITE, 0, 7, 3));
        send_beat(make_item(ACT_WRITE, 7, 0, 1));
        send_beat(make_item(ACT_WRITE, 0, 0, 2));
        send_beat(make_item(ACT_WRITE, 3, 4, 0));
        send_beat(make_item(ACT_READ, 7, 7, 0));
        repeat (3) send_beat(make_item(ACT_STEP, 0, 0, 0));
        send_beat(make_item(ACT_READ, 0, 0, 7));
        send_beat(make_item(ACT_CLEAR, 7, 7, 7));
        // blinker, then knock out its centre so the grid dies
        send_beat(make_item(ACT_WRITE, 2, 3, 5));
        send_beat(make_item(ACT_WRITE, 3, 3, 5));
        send_beat(make_item(ACT_WRITE, 4, 3, 5));
        repeat (2) send_beat(make_item(ACT_STEP, 7, 7, 7));
        send_beat(make_item(ACT_READ, 3, 3, 0));
        send_beat(make_item(ACT_WRITE, 3, 3, 0));
        send_beat(make_item(ACT_STEP, 0, 0, 0));
        send_beat(make_item(ACT_READ, 7, 7, 0));

        drain();
        set_config(3'd0, 8'd0);
        run_phase(200, 4, 40);

        drain();
        set_config(3'd1, 8'd255);
        sender_idles = 1'b0;
        run_phase(200, 4, 40);

        drain();
        set_config(3'd7, 8'd1);
        sender_idles = 1'b1;
        run_phase(200, 4, 40);

        drain();
        set_config(3'($urandom), 8'($urandom));
        run_phase(200, 4, 40);

        // one clear, then no more clears, so the count runs into saturation
        drain();
        set_config(3'd5, 8'd200);
        send_beat(make_item(ACT_CLEAR, $urandom, $urandom, $urandom));
        run_phase(450, 0, 62);
        drain();

        $display("ran %0d clears, %0d writes, %0d reads and %0d steps over six settings",
                 tracker.n_clear, tracker.n_write, tracker.n_read, tracker.n_step);
        $display("steps: %0d to an empty grid, %0d steady, %0d at limit; count peaked at %0d",
                 tracker.n_empty, tracker.n_same, tracker.n_limit, tracker.top_gen);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
src/lgas_pkg.sv
src/lgas_ram.sv
src/lgas_front.sv
src/lgas_queue.sv
src/lgas_back.sv
src/life_grid_aging_step.sv
sim/tb_life_grid_aging_step.sv
